// ===== hw/rtl/size_class_pool_allocator_unit_defines.svh =====
// Assertion macros for the allocator.
`ifndef SIZE_CLASS_POOL_ALLOCATOR_UNIT_DEFINES_SVH
`define SIZE_CLASS_POOL_ALLOCATOR_UNIT_DEFINES_SVH

// Implication checked on every clock, off in reset.
`define SCPA_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Next-cycle implication.
`define SCPA_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// ===== hw/rtl/scpa_pkg.sv =====
`timescale 1ns / 1ps
package scpa_pkg;
    localparam int POOL_BYTES_DEF   = 1048576;
    localparam int HEADER_BYTES_DEF = 24;
    localparam int NUM_CLASSES_DEF  = 24;

    localparam int OFS_W  = 20;
    localparam int TOT_W  = 21;
    localparam int IDX_W  = 15;
    localparam int CLS_W  = 5;
    localparam int GROSS_W = 34;
    localparam int QDEPTH = 2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_SPACE = 2'd1;
    localparam logic [1:0] ST_ALIGN = 2'd2;
    localparam logic [1:0] ST_LARGE = 2'd3;

    // Class size as a log2 value; 64, 2K and 2M are skipped.
    function automatic logic [5:0] class_log2(input logic [CLS_W-1:0] c);
        logic [5:0] r;
        begin
            unique case (c)
                5'd0:    r = 6'd5;
                5'd1:    r = 6'd7;
                5'd2:    r = 6'd8;
                5'd3:    r = 6'd9;
                5'd4:    r = 6'd10;
                default: r = (c <= 5'd13) ? 6'(c) + 6'd7 : 6'(c) + 6'd8;
            endcase
            return r;
        end
    endfunction

    // Classified request handed from front to back.
    typedef struct packed {
        logic              is_free;
        logic              present;
        logic [1:0]        status;
        logic [CLS_W-1:0]  cls;
        logic [IDX_W-1:0]  idx;
        logic [31:0]       align_m1;
    } cmd_t;
endpackage

// ===== hw/rtl/scpa_ram.sv =====
`timescale 1ns / 1ps
module scpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/scpa_front.sv =====
`timescale 1ns / 1ps
module scpa_front
    import scpa_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int NUM_CLASSES  = NUM_CLASSES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        action,
    input  logic [31:0] request_bytes,
    input  logic [31:0] alignment,
    input  logic [19:0] block_offset_in,
    input  logic        handle_present,
    output logic        q_valid,
    output cmd_t        q_cmd,
    input  logic        q_take
);
    localparam int NCLS = (NUM_CLASSES > 32) ? 32 : NUM_CLASSES;

    cmd_t             q_reg [QDEPTH];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;
    cmd_t             cmd;
    logic [GROSS_W-1:0] gross;
    logic             found;
    logic [CLS_W-1:0] cls;
    logic [5:0]       lg;

    // Gross size against each class limit, first fit.
    always_comb
    begin
        gross = GROSS_W'(request_bytes) + GROSS_W'(HEADER_BYTES) + GROSS_W'(alignment)
              - GROSS_W'(1);
        found = 1'b0;
        cls   = '0;
        lg    = '0;
        for (int c = NCLS - 1; c >= 0; c--)
        begin
            lg = class_log2(CLS_W'(c));
            if (gross <= (GROSS_W'(1) << lg))
            begin
                found = 1'b1;
                cls   = CLS_W'(c);
            end
        end
        cmd.is_free  = action;
        cmd.present  = handle_present;
        cmd.idx      = block_offset_in[OFS_W-1:5];
        cmd.align_m1 = alignment - 32'd1;
        cmd.cls      = cls;
        if (action)
            cmd.status = ST_DONE;
        else if (alignment == 32'd0 || (alignment & (alignment - 32'd1)) != 32'd0)
            cmd.status = ST_ALIGN;
        else if (!found)
            cmd.status = ST_LARGE;
        else
            cmd.status = ST_DONE;
    end

    assign full    = (cnt_reg == 2'(QDEPTH));
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            q_reg[wp_reg] <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push && !full)
                wp_reg <= ~wp_reg;
            if (q_take)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push && !full) - 2'(q_take);
        end
    end
endmodule

// ===== hw/rtl/scpa_back.sv =====
`timescale 1ns / 1ps
module scpa_back
    import scpa_pkg::*;
#(
    parameter int POOL_BYTES   = POOL_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [20:0] cfg_wdata,
    input  logic        q_valid,
    input  cmd_t        q_cmd,
    output logic        q_take,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic [19:0] block_offset,
    output logic [19:0] data_offset,
    output logic [20:0] allocated_bytes
);
    localparam logic [31:0] CAP_MAX = (POOL_BYTES >= (1 << TOT_W)) ?
                                      32'((1 << TOT_W) - 1) : 32'(POOL_BYTES);

    typedef enum logic [1:0] {S_CMD = 2'b01, S_LINK = 2'b10} bst_t;

    bst_t             st_reg;
    logic [15:0]      heads_reg [32];
    logic [TOT_W-1:0] cap_reg, bump_reg, tot_reg;
    cmd_t             cur_reg;
    logic [1:0]       o_st_reg [2];
    logic [OFS_W-1:0] o_blk_reg [2];
    logic [OFS_W-1:0] o_dat_reg [2];
    logic [TOT_W-1:0] o_tot_reg [2];
    logic             ow_reg, or_reg;
    logic [1:0]       ocnt_reg;

    logic             room, emit;
    logic [1:0]       e_st;
    logic [OFS_W-1:0] e_blk, e_dat;
    logic [TOT_W-1:0] tot_new, csz, cap_eff;
    logic [31:0]      dsum;
    logic [15:0]      head;
    logic [40:0]      bsum, csz_w;
    logic             l_we, c_we;
    logic [15:0]      l_wd, l_rd;
    logic [4:0]       c_rd;
    logic [IDX_W-1:0] rd_idx;

    // class read holds the taken block while the link step waits
    assign rd_idx = (st_reg == S_LINK) ? cur_reg.idx : q_cmd.idx;

    scpa_ram #(.WIDTH(16), .DEPTH(1 << IDX_W)) u_links (
        .clk(clk), .we(l_we), .waddr(cur_reg.idx), .wdata(l_wd),
        .raddr(head[IDX_W-1:0]), .rdata(l_rd));
    scpa_ram #(.WIDTH(CLS_W), .DEPTH(1 << IDX_W)) u_class (
        .clk(clk), .we(c_we), .waddr(c_we ? bump_reg[OFS_W-1:5] : rd_idx),
        .wdata(q_cmd.cls), .raddr(rd_idx), .rdata(c_rd));

    assign room    = (ocnt_reg != 2'd2);
    assign empty   = (ocnt_reg == 2'd0);
    assign status          = o_st_reg[or_reg];
    assign block_offset    = o_blk_reg[or_reg];
    assign data_offset     = o_dat_reg[or_reg];
    assign allocated_bytes = o_tot_reg[or_reg];
    assign cap_eff = (32'(cap_reg) > CAP_MAX) ? TOT_W'(CAP_MAX) : cap_reg;

    // Free: the command step reads the class, the link step links and pushes.
    // Alloc with list hit: the command step reads the link of the head, the link step pops.
    always_comb
    begin
        cmd_t c;
        logic [4:0] k;
        c = (st_reg == S_LINK) ? cur_reg : q_cmd;
        k = (st_reg == S_LINK && c.is_free) ? c_rd : c.cls;
        head   = heads_reg[k];
        csz_w  = 41'd1 << class_log2(k);
        csz    = csz_w[TOT_W-1:0];
        q_take = 1'b0;
        emit   = 1'b0;
        e_st   = ST_DONE;
        e_blk  = '0;
        e_dat  = '0;
        tot_new = tot_reg;
        l_we = 1'b0;
        l_wd = head;
        c_we = 1'b0;
        bsum = 41'(bump_reg) + csz_w;
        dsum = '0;
        if (st_reg == S_LINK)
        begin
            if (room)
            begin
                emit = 1'b1;
                if (c.is_free)
                begin
                    tot_new = tot_reg - csz;
                    e_blk   = {c.idx, 5'd0};
                end
                else
                begin
                    tot_new = tot_reg + csz;
                    e_blk   = {head[IDX_W-1:0], 5'd0};
                    dsum    = 32'(e_blk) + 32'(HEADER_BYTES) + c.align_m1;
                    e_dat   = dsum[OFS_W-1:0] & ~c.align_m1[OFS_W-1:0];
                end
            end
        end
        else if (q_valid && room)
        begin
            if (c.is_free)
            begin
                q_take = 1'b1;
                emit   = !c.present;
            end
            else if (c.status != ST_DONE)
            begin
                q_take = 1'b1;
                emit   = 1'b1;
                e_st   = c.status;
            end
            else if (head[15])
            begin
                q_take = 1'b1;
            end
            else
            begin
                q_take = 1'b1;
                emit   = 1'b1;
                if (bsum > 41'(cap_eff))
                    e_st = ST_SPACE;
                else
                begin
                    c_we    = 1'b1;
                    tot_new = tot_reg + csz;
                    e_blk   = bump_reg[OFS_W-1:0];
                    dsum    = 32'(e_blk) + 32'(HEADER_BYTES) + c.align_m1;
                    e_dat   = dsum[OFS_W-1:0] & ~c.align_m1[OFS_W-1:0];
                end
            end
        end
        if (st_reg == S_LINK && room && c.is_free)
            l_we = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (q_take)
            cur_reg <= q_cmd;
        if (emit)
        begin
            o_st_reg[ow_reg]  <= e_st;
            o_blk_reg[ow_reg] <= e_blk;
            o_dat_reg[ow_reg] <= e_dat;
            o_tot_reg[ow_reg] <= tot_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_CMD;
            cap_reg  <= TOT_W'(1 << 20);
            bump_reg <= '0;
            tot_reg  <= '0;
            ow_reg   <= 1'b0;
            or_reg   <= 1'b0;
            ocnt_reg <= 2'd0;
            for (int i = 0; i < 32; i++)
                heads_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            if (emit)
                ow_reg <= ~ow_reg;
            if (pop && !empty)
                or_reg <= ~or_reg;
            ocnt_reg <= ocnt_reg + 2'(emit) - 2'(pop && !empty);
            tot_reg  <= tot_new;
            if (c_we)
                bump_reg <= bsum[TOT_W-1:0];
            unique case (st_reg)
                S_CMD:
                begin
                    if (q_take && ((q_cmd.is_free && q_cmd.present) ||
                        (!q_cmd.is_free && q_cmd.status == ST_DONE && head[15])))
                        st_reg <= S_LINK;
                end
                S_LINK:
                begin
                    if (room)
                    begin
                        st_reg <= S_CMD;
                        if (cur_reg.is_free)
                            heads_reg[c_rd] <= {1'b1, cur_reg.idx};
                        else
                            heads_reg[cur_reg.cls] <= l_rd;
                    end
                end
                default: st_reg <= S_CMD;
            endcase
        end
    end
endmodule

// ===== hw/rtl/size_class_pool_allocator_unit.sv =====
`timescale 1ns / 1ps
// Channel  | Handshake          | Payload
// request  | push / full        | action, request_bytes, alignment, block_offset_in,
//          |                    | handle_present
// result   | empty / pop        | status, block_offset, data_offset, allocated_bytes
// config   | cfg_we             | cfg_wdata (pool_capacity)
// Failed allocates, bump allocates and null frees finish in the command step; a
// list pop or a free also takes the link step (head/class read, then link memory).
// Reset clears lists, bump pointer and total at once; link and class memories
// are not cleared. A full result queue stalls the back end; the two-entry
// request queue keeps taking requests until it fills.
`include "size_class_pool_allocator_unit_defines.svh"
module size_class_pool_allocator_unit
    import scpa_pkg::*;
#(
    parameter int POOL_BYTES   = POOL_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int NUM_CLASSES  = NUM_CLASSES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        action,
    input  logic [31:0] request_bytes,
    input  logic [31:0] alignment,
    input  logic [19:0] block_offset_in,
    input  logic        handle_present,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic [19:0] block_offset,
    output logic [19:0] data_offset,
    output logic [20:0] allocated_bytes,
    input  logic        cfg_we,
    input  logic [20:0] cfg_wdata
);
    logic q_valid, q_take;
    cmd_t q_cmd;

    // front end: classify and queue
    scpa_front #(.HEADER_BYTES(HEADER_BYTES), .NUM_CLASSES(NUM_CLASSES)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .action(action),
        .request_bytes(request_bytes), .alignment(alignment),
        .block_offset_in(block_offset_in), .handle_present(handle_present),
        .q_valid(q_valid), .q_cmd(q_cmd), .q_take(q_take));

    // back end: lists, bump pointer, result queue
    scpa_back #(.POOL_BYTES(POOL_BYTES), .HEADER_BYTES(HEADER_BYTES)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .q_valid(q_valid), .q_cmd(q_cmd), .q_take(q_take), .empty(empty),
        .pop(pop), .status(status), .block_offset(block_offset),
        .data_offset(data_offset), .allocated_bytes(allocated_bytes));

    `SCPA_ASSERT_IMP(a_take_valid, clk, rst_n, q_take, q_valid, "take from empty queue")
    `SCPA_ASSERT_IMP(a_fail_zero, clk, rst_n, !empty && status != ST_DONE,
        block_offset == 20'd0 && data_offset == 20'd0, "failed result has offsets")
    `SCPA_ASSERT_NXT(a_full_hold, clk, rst_n, full && !q_take, full, "queue lost entry")
endmodule
